@@ rtl/bsg_pkg.sv @@
// Shared types, constants and helpers for the bilevel supersample to gray core.
`timescale 1ns / 1ps

package bsg_pkg;

    localparam int LANES        = 8;
    localparam int LANE_W       = 3;
    localparam int COUNT_W      = 7;
    localparam int Q_W          = 2;
    localparam int OUT_WIDTH_W  = 10;
    localparam int CFG_DATA_W   = 10;
    localparam int CFG_INDEX_W  = 1;
    localparam int BYTE_INDEX_W = 9;
    localparam int ROW_PHASE_W  = 3;
    localparam int COLUMN_W     = 9;
    localparam int GRAY_W       = 8;
    localparam int ONES_W       = 4;

    localparam logic [OUT_WIDTH_W-1:0] OUT_WIDTH_RESET = 10'd512;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_QUALITY_SHIFT = 1'b0,
        CFG_OUT_WIDTH     = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic [7:0] bits;
        logic       row_end;
    } bsg_in_t;

    typedef struct packed {
        logic [GRAY_W-1:0]   gray;
        logic [COLUMN_W-1:0] column;
        logic                last;
    } bsg_out_t;

    // One byte's worth of results, one slot per lane of a line-store row
    typedef struct packed {
        logic [LANES-1:0]                 pend;
        logic [COLUMN_W-LANE_W-1:0]       row;
        logic [LANES-1:0][GRAY_W-1:0]     gray;
    } bsg_group_t;

    // Ink count of the k-th block of a byte, block width 2^q
    function automatic logic [ONES_W-1:0] block_ones(input logic [7:0] bits,
                                                     input logic [LANE_W-1:0] k,
                                                     input logic [Q_W-1:0] q);
        logic [5:0]        amt;
        logic [7:0]        shifted;
        logic [7:0]        win;
        logic [ONES_W-1:0] n;
        amt     = {3'b000, k} << q;
        shifted = bits << amt;
        win     = shifted & ~(8'hFF >> (4'd1 << q));
        n       = '0;
        for (int i = 0; i < 8; i++)
        begin
            n = n + {{(ONES_W-1){1'b0}}, win[i]};
        end
        return n;
    endfunction

    // (count * 255) >> 2q, saturated to 255
    function automatic logic [GRAY_W-1:0] gray_of(input logic [COUNT_W-1:0] cnt,
                                                  input logic [Q_W-1:0] q);
        logic [14:0] prod;
        logic [14:0] shifted;
        prod    = {cnt, 8'b0} - {8'b0, cnt};
        shifted = prod >> {q, 1'b0};
        if (shifted > 15'd255)
        begin
            return 8'hFF;
        end
        return shifted[GRAY_W-1:0];
    endfunction

endpackage

@@ rtl/bsg_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module bsg_ram #(
    parameter int WIDTH = 56,
    parameter int DEPTH = 64,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/bsg_emit.sv @@
// Result group buffer: holds one byte's gray pixels and sends them one item at a time.
`timescale 1ns / 1ps

module bsg_emit (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  bsg_pkg::bsg_group_t group,
    output logic              free,
    output logic              out_valid,
    input  logic              out_stall,
    output bsg_pkg::bsg_out_t out_data
);

    import bsg_pkg::*;

    logic [LANES-1:0]             pend_reg;
    logic [LANES-1:0]             pend_next;
    logic [COLUMN_W-LANE_W-1:0]   row_reg;
    logic [LANES-1:0][GRAY_W-1:0] gray_reg;
    logic [LANE_W-1:0]            sel;
    logic [LANES-1:0]             sel_bit;
    logic                         fire;

    always_comb
    begin
        sel = '0;
        for (int j = LANES - 1; j >= 0; j--)
        begin
            if (pend_reg[j])
            begin
                sel = LANE_W'(j);
            end
        end
        sel_bit   = LANES'(1) << sel;
        out_valid = |pend_reg;
        fire      = out_valid && !out_stall;
        pend_next = fire ? (pend_reg & ~sel_bit) : pend_reg;
        free      = (pend_next == '0);

        out_data.gray   = gray_reg[sel];
        out_data.column = {row_reg, sel};
        out_data.last   = ((pend_reg & ~sel_bit) == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else if (load)
        begin
            pend_reg <= group.pend;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            row_reg  <= group.row;
            gray_reg <= group.gray;
        end
    end

endmodule

@@ rtl/bilevel_supersample_to_gray_core.sv @@
// Top level of the bilevel supersample to gray core.
// Takes one packed 1-bit pixel byte per cycle unless stalled and keeps per-column ink counts
// in a line store organized as rows of 8 columns; each byte does one read-modify-write of a
// row, with the last write forwarded so back-to-back bytes on the same row see fresh counts.
// A byte causing at most one gray pixel does not hold the input back; one causing more holds
// it while the output sends its pixels, one per item and per cycle unless stalled. Each byte
// passes the stage 0 and stage 1 registers before its first pixel is offered. The line store
// needs no clearing after reset: the first row of each group overwrites the counts it uses.
`timescale 1ns / 1ps

module bilevel_supersample_to_gray_core #(
    parameter int MAX_OUT_WIDTH = 512
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [bsg_pkg::CFG_INDEX_W-1:0]    cfg_addr,
    input  logic [bsg_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  bsg_pkg::bsg_in_t                   in_data,
    output logic                               out_valid,
    input  logic                               out_stall,
    output bsg_pkg::bsg_out_t                  out_data
);

    import bsg_pkg::*;

    localparam int DEPTH  = (MAX_OUT_WIDTH + LANES - 1) / LANES;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int COLF_W = BYTE_INDEX_W + LANE_W;
    localparam logic [COLF_W:0]       MAX_COLS  = (COLF_W + 1)'(MAX_OUT_WIDTH);
    localparam logic [BYTE_INDEX_W:0] DEPTH_ROW = (BYTE_INDEX_W + 1)'(DEPTH);

    // configuration
    logic [Q_W-1:0]         q_reg;
    logic [OUT_WIDTH_W-1:0] out_width_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_reg         <= '0;
            out_width_reg <= OUT_WIDTH_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index_t'(cfg_addr))
                CFG_QUALITY_SHIFT: q_reg <= cfg_wdata[Q_W-1:0];
                CFG_OUT_WIDTH:     out_width_reg <= cfg_wdata[OUT_WIDTH_W-1:0];
                default: ;
            endcase
        end
    end

    // row position tracking
    logic [BYTE_INDEX_W-1:0] byte_index_reg, byte_index_next;
    logic [ROW_PHASE_W-1:0]  row_phase_reg, row_phase_next;
    logic [3:0]              span_m1;
    logic                    first_now;
    logic                    emit_now;
    logic                    in_fire;

    // stage 0: input register, line-store read issued from here
    logic                    s0_valid_reg, s0_valid_next;
    logic [7:0]              s0_bits_reg;
    logic [Q_W-1:0]          s0_q_reg;
    logic                    s0_first_reg;
    logic                    s0_emit_reg;
    logic [BYTE_INDEX_W-1:0] s0_row_reg;
    logic [LANE_W-1:0]       s0_grp_reg;
    logic                    s0_adv;

    // stage 1: count update and write-back
    logic                    s1_valid_reg, s1_valid_next;
    logic                    s1_new_reg;
    logic [7:0]              s1_bits_reg;
    logic [Q_W-1:0]          s1_q_reg;
    logic                    s1_first_reg;
    logic                    s1_emit_reg;
    logic [BYTE_INDEX_W-1:0] s1_row_reg;
    logic [LANE_W-1:0]       s1_grp_reg;
    logic [LANES-1:0][COUNT_W-1:0] s1_base_reg;
    logic                    s1_fire;

    // line store and write forwarding
    logic [LANES-1:0][COUNT_W-1:0] ram_rdata;
    logic [LANES-1:0][COUNT_W-1:0] base;
    logic [LANES-1:0][COUNT_W-1:0] new_row;
    logic                    ram_we;
    logic                    lw_valid_reg;
    logic [ADDR_W-1:0]       lw_addr_reg;
    logic [LANES-1:0][COUNT_W-1:0] lw_data_reg;
    logic                    fwd;
    logic                    row_stored;

    bsg_group_t              grp;
    logic                    emit_free;
    logic                    emit_load;

    always_comb
    begin
        span_m1   = (4'd1 << q_reg) - 4'd1;
        first_now = (row_phase_reg == '0);
        emit_now  = ({1'b0, row_phase_reg} >= span_m1);
        in_fire   = in_valid && !in_stall;

        byte_index_next = byte_index_reg;
        row_phase_next  = row_phase_reg;
        if (in_fire)
        begin
            if (in_data.row_end)
            begin
                byte_index_next = '0;
                row_phase_next  = emit_now ? '0 : row_phase_reg + 3'd1;
            end
            else
            begin
                byte_index_next = byte_index_reg + 9'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_index_reg <= '0;
            row_phase_reg  <= '0;
        end
        else
        begin
            byte_index_reg <= byte_index_next;
            row_phase_reg  <= row_phase_next;
        end
    end

    // handshake and stage control
    always_comb
    begin
        s0_adv        = s0_valid_reg && (!s1_valid_reg || s1_fire);
        in_stall      = s0_valid_reg && !s0_adv;
        s0_valid_next = in_fire ? 1'b1 : (s0_adv ? 1'b0 : s0_valid_reg);
        s1_valid_next = s0_adv ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
            s1_new_reg   <= 1'b0;
            lw_valid_reg <= 1'b0;
        end
        else
        begin
            s0_valid_reg <= s0_valid_next;
            s1_valid_reg <= s1_valid_next;
            s1_new_reg   <= s0_adv;
            lw_valid_reg <= ram_we;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s0_bits_reg  <= in_data.bits;
            s0_q_reg     <= q_reg;
            s0_first_reg <= first_now;
            s0_emit_reg  <= emit_now;
            s0_row_reg   <= byte_index_reg >> q_reg;
            s0_grp_reg   <= byte_index_reg[LANE_W-1:0] & span_m1[LANE_W-1:0];
        end
        if (s0_adv)
        begin
            s1_bits_reg  <= s0_bits_reg;
            s1_q_reg     <= s0_q_reg;
            s1_first_reg <= s0_first_reg;
            s1_emit_reg  <= s0_emit_reg;
            s1_row_reg   <= s0_row_reg;
            s1_grp_reg   <= s0_grp_reg;
        end
        if (s1_valid_reg)
        begin
            s1_base_reg <= base;
        end
        if (ram_we)
        begin
            lw_addr_reg <= s1_row_reg[ADDR_W-1:0];
            lw_data_reg <= new_row;
        end
    end

    bsg_ram #(
        .WIDTH(LANES * COUNT_W),
        .DEPTH(DEPTH)
    ) u_counts (
        .clk  (clk),
        .we   (ram_we),
        .waddr(s1_row_reg[ADDR_W-1:0]),
        .wdata(new_row),
        .raddr(s0_row_reg[ADDR_W-1:0]),
        .rdata(ram_rdata)
    );

    // per-lane count update and gray conversion
    always_comb
    begin
        logic [LANE_W-1:0] pbm1;
        logic [LANE_W-1:0] lane_k;
        logic [LANE_W-1:0] lane_grp;
        logic [COLF_W-1:0] col_full;
        logic              touched;
        logic              stored;
        logic              visible;
        logic [ONES_W-1:0] ones;
        logic [COUNT_W-1:0] cnt;

        fwd  = lw_valid_reg && (lw_addr_reg == s1_row_reg[ADDR_W-1:0]);
        base = s1_new_reg ? (fwd ? lw_data_reg : ram_rdata) : s1_base_reg;
        pbm1 = LANE_W'((4'd8 >> s1_q_reg) - 4'd1);

        grp.row = s1_row_reg[COLUMN_W-LANE_W-1:0];
        for (int j = 0; j < LANES; j++)
        begin
            lane_k   = LANE_W'(j) & pbm1;
            lane_grp = LANE_W'(j) >> (2'd3 - s1_q_reg);
            touched  = (lane_grp == s1_grp_reg);
            col_full = {s1_row_reg, LANE_W'(j)};
            stored   = ({1'b0, col_full} < MAX_COLS);
            visible  = (col_full < COLF_W'(out_width_reg));
            ones     = block_ones(s1_bits_reg, lane_k, s1_q_reg);
            cnt      = (s1_first_reg ? '0 : base[j]) + COUNT_W'(ones);

            new_row[j]  = (touched && stored) ? cnt : base[j];
            grp.gray[j] = gray_of(cnt, s1_q_reg);
            grp.pend[j] = touched && stored && s1_emit_reg && visible;
        end

        row_stored = ({1'b0, s1_row_reg} < DEPTH_ROW);
        s1_fire    = s1_valid_reg && (emit_free || (grp.pend == '0));
        ram_we     = s1_fire && row_stored;
        emit_load  = s1_fire && (grp.pend != '0);
    end

    bsg_emit u_emit (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (emit_load),
        .group    (grp),
        .free     (emit_free),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data (out_data)
    );

endmodule

@@ rtl/bsg_checker.sv @@
// Port-level checks for the bilevel supersample to gray core, bound to the top level.
`timescale 1ns / 1ps

module bsg_checker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              out_valid,
    input  logic              out_stall,
    input  bsg_pkg::bsg_out_t out_data
);

    // held item must not change while stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("output item changed while stalled");

    // pixels of one byte follow back to back in adjacent columns
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !out_data.last
        |=> out_valid && (out_data.column == $past(out_data.column) + 9'd1))
        else $error("byte result sequence broken");

    // nothing is offered once reset has been sampled low
    assert property (@(posedge clk) !rst_n |=> !out_valid)
        else $error("output valid during reset");

endmodule

bind bilevel_supersample_to_gray_core bsg_checker u_bsg_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
);

@@ tb/tb_bilevel_supersample_to_gray_core.sv @@
// Self-checking testbench for the bilevel supersample to gray core.
`timescale 1ns / 1ps

module tb_bilevel_supersample_to_gray_core;
    import bsg_pkg::*;

    localparam int LINE_COLS = 512;
    localparam int RUN_LIMIT = 400000;
    localparam int HOLD_CYCLES = 300;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic in_valid = 1'b0;
    bsg_in_t in_data = '0;
    logic out_stall = 1'b0;
    logic in_stall;
    logic out_valid;
    bsg_out_t out_data;

    bsg_in_t byte_queue [$];
    bsg_out_t pixels_due [$];
    bsg_out_t pixel_want;

    // gray model state
    int cur_q = 0;
    int cur_width = 512;
    int pos_byte = 0;
    int pos_row = 0;
    logic [6:0] line_counts [LINE_COLS];

    // stimulus-side row tracking, keeps later rows on columns of the group's first row
    int gen_byte = 0;
    int gen_row = 0;
    bit gen_written [LINE_COLS];

    int send_idle_pct = 0;
    int stall_pct = 0;
    bit hold_req = 1'b0;
    bit hold_used = 1'b0;
    int hold_left = 0;
    int mismatches = 0;
    int cycles = 0;
    int i;

    bilevel_supersample_to_gray_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic int ink_count(input int v);
        int n;
        int b;
        n = 0;
        for (b = 0; b < 8; b++)
        begin
            n += (v >> b) & 1;
        end
        return n;
    endfunction

    task automatic reduce_byte(input bsg_in_t item);
        int span;
        int per_byte;
        int k;
        int col;
        int sh;
        int cnt;
        int level;
        int n;
        bit first_row;
        bit emit_row;
        bsg_out_t px [8];
        span = 1 << cur_q;
        per_byte = 8 >> cur_q;
        first_row = (pos_row == 0);
        emit_row = (pos_row >= span - 1);
        n = 0;
        for (k = 0; k < per_byte; k++)
        begin
            col = pos_byte * per_byte + k;
            sh = 8 - (k + 1) * span;
            cnt = ink_count((item.bits >> sh) & ((1 << span) - 1));
            if (col < LINE_COLS)
            begin
                if (!first_row)
                    cnt += int'(line_counts[col]);
                cnt &= 127;
                line_counts[col] = cnt[6:0];
                if (emit_row && col < cur_width)
                begin
                    level = (cnt * 255) >> (2 * cur_q);
                    px[n].gray = (level > 255) ? 8'd255 : level[7:0];
                    px[n].column = col[8:0];
                    px[n].last = 1'b0;
                    n++;
                end
            end
        end
        for (k = 0; k < n; k++)
        begin
            px[k].last = (k == n - 1);
            pixels_due.push_back(px[k]);
        end
        if (item.row_end)
        begin
            pos_byte = 0;
            pos_row = emit_row ? 0 : (pos_row + 1) & 7;
        end
        else
            pos_byte = (pos_byte + 1) & 511;
    endtask

    function automatic bit cols_written(input int idx);
        int per_byte;
        int k;
        int col;
        per_byte = 8 >> cur_q;
        for (k = 0; k < per_byte; k++)
        begin
            col = idx * per_byte + k;
            if (col < LINE_COLS && !gen_written[col])
                return 1'b0;
        end
        return 1'b1;
    endfunction

    // later rows of a group are cut short before they reach unwritten columns
    task automatic queue_byte(input logic [7:0] bits, input bit want_end);
        int per_byte;
        int k;
        int col;
        int nxt;
        bsg_in_t item;
        per_byte = 8 >> cur_q;
        for (k = 0; k < per_byte; k++)
        begin
            col = gen_byte * per_byte + k;
            if (col < LINE_COLS)
                gen_written[col] = 1'b1;
        end
        nxt = (gen_byte + 1) & 511;
        item.bits = bits;
        item.row_end = want_end || (gen_row != 0 && !cols_written(nxt));
        if (item.row_end)
        begin
            gen_byte = 0;
            gen_row = (gen_row >= (1 << cur_q) - 1) ? 0 : (gen_row + 1) & 7;
            if (gen_row == 0)
                gen_written = '{default: 1'b0};
        end
        else
            gen_byte = nxt;
        byte_queue.push_back(item);
    endtask

    function automatic logic [7:0] random_bits();
        int pick;
        pick = $urandom_range(99);
        if (pick < 20)
            return 8'hFF;
        if (pick < 30)
            return 8'h00;
        return 8'($urandom_range(255));
    endfunction

    function automatic int random_width();
        if ($urandom_range(9) == 0)
            return $urandom_range(1023);
        return $urandom_range(1, 512);
    endfunction

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] v);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_QUALITY_SHIFT)
            cur_q = int'(v[1:0]);
        else
            cur_width = int'(v);
    endtask

    task automatic set_config(input int q, input int width);
        logic [CFG_DATA_W-1:0] v;
        v = CFG_DATA_W'($urandom);
        v[1:0] = 2'(q);
        write_reg(CFG_QUALITY_SHIFT, v);
        write_reg(CFG_OUT_WIDTH, CFG_DATA_W'(width));
        @(negedge clk);
    endtask

    task automatic set_idle(input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        stall_pct = recv_pct;
    endtask

    // wait for the pipe to empty, then for any item still in flight
    task automatic settle();
        do
            @(negedge clk);
        while (byte_queue.size() != 0 || in_valid || pixels_due.size() != 0);
        repeat (16) @(negedge clk);
    endtask

    // mostly well-formed groups: later rows no longer than the first
    task automatic random_rows(input int n_items, input int max_len);
        int left;
        int len;
        int first_len;
        int r;
        int b;
        left = n_items;
        while (left > 0)
        begin
            first_len = ($urandom_range(9) == 0) ? $urandom_range(1, max_len)
                                                 : $urandom_range(1, 8);
            len = first_len;
            for (r = 0; r < (1 << cur_q) && left > 0; r++)
            begin
                if (r > 0)
                    len = ($urandom_range(9) == 0) ? $urandom_range(1, max_len)
                                                   : $urandom_range(1, first_len);
                for (b = 0; b < len && left > 0; b++)
                begin
                    queue_byte(random_bits(), b == len - 1 || left == 1);
                    left--;
                end
            end
        end
        // finish the open group before the quality can change
        while (gen_row != 0)
            queue_byte(random_bits(), 1'b1);
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                reduce_byte(in_data);
            if (!in_valid || !in_stall)
            begin
                if (byte_queue.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    in_data <= byte_queue.pop_front();
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (hold_req && !hold_used)
        begin
            hold_used = 1'b1;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pixels_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected pixel: gray %0d column %0d last %0b",
                             out_data.gray, out_data.column, out_data.last);
            end
            else
            begin
                pixel_want = pixels_due.pop_front();
                if (out_data.gray !== pixel_want.gray ||
                    out_data.column !== pixel_want.column ||
                    out_data.last !== pixel_want.last)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("pixel mismatch: want gray %0d column %0d last %0b, ",
                                 pixel_want.gray, pixel_want.column, pixel_want.last,
                                 "got %0d %0d %0b",
                                 out_data.gray, out_data.column, out_data.last);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > RUN_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        // width cut inside a byte, then a byte wholly past the width
        set_config(0, 9);
        queue_byte(8'hFF, 1'b0);
        queue_byte(8'h00, 1'b0);
        queue_byte(8'hA5, 1'b1);
        settle();
        // zero width: nothing comes out
        set_config(0, 0);
        queue_byte(8'hFF, 1'b1);
        settle();
        set_config(1, 512);
        queue_byte(8'hFF, 1'b0);
        queue_byte(8'h0F, 1'b1);
        queue_byte(8'h81, 1'b0);
        queue_byte(8'hF0, 1'b1);
        settle();
        set_config(2, 1);
        queue_byte(8'hFF, 1'b1);
        queue_byte(8'hC3, 1'b1);
        queue_byte(8'h3C, 1'b1);
        queue_byte(8'h80, 1'b1);
        settle();
        // two full rows at q=3, then q=1 mid-group: gray saturates
        set_config(3, 512);
        for (i = 0; i < 8; i++)
            queue_byte(8'hFF, i % 4 == 3);
        settle();
        set_config(1, 512);
        queue_byte(8'hFF, 1'b1);
        settle();

        set_config(0, 512);
        set_idle(0, 0);
        random_rows(50, 12);
        settle();
        set_config(1, 1023);
        set_idle(85, 0);
        random_rows(50, 12);
        settle();
        set_config(2, random_width());
        set_idle(0, 85);
        random_rows(50, 12);
        settle();
        set_config(3, random_width());
        set_idle(31, 31);
        random_rows(50, 12);
        settle();

        // long output hold while the sender keeps offering
        set_config(0, 512);
        set_idle(0, 0);
        random_rows(40, 8);
        hold_req = 1'b1;
        settle();

        for (i = 0; i < 5; i++)
        begin
            set_config($urandom_range(3), random_width());
            case (i % 4)
                0: set_idle(31, 31);
                1: set_idle(85, 0);
                2: set_idle(0, 85);
                default: set_idle(0, 0);
            endcase
            random_rows(24, 16);
            settle();
        end

        if (mismatches == 0 && pixels_due.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

@@ bilevel_supersample_to_gray_core.f @@
rtl/bsg_pkg.sv
rtl/bsg_ram.sv
rtl/bsg_emit.sv
rtl/bilevel_supersample_to_gray_core.sv
rtl/bsg_checker.sv
tb/tb_bilevel_supersample_to_gray_core.sv
